@@ rtl/bba_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the buddy block allocator.
package bba_pkg;

  localparam int unsigned MinBlockBytes = 1024;
  localparam int unsigned HeaderBytes   = 4;
  localparam int unsigned LvlW          = 4;
  localparam int unsigned CodeW         = LvlW + 1;
  localparam int unsigned AddrW         = 32;
  localparam int unsigned SizeW         = 21;
  localparam int unsigned StatusW       = 2;

  // Result status codes, as seen on status_o.
  typedef enum logic [StatusW-1:0] {
    RES_ALLOC  = 2'd0,
    RES_FAIL   = 2'd1,
    RES_FREED  = 2'd2,
    RES_IGNORE = 2'd3
  } res_e;

  // Free-store address select.
  typedef enum logic [1:0] {
    FSEL_NODE  = 2'd0,
    FSEL_NEXT  = 2'd1,
    FSEL_BUDDY = 2'd2
  } fsel_e;

  typedef struct packed {
    logic  capture;
    logic  clr;
    logic  scan_init;
    logic  scan_next;
    logic  split_down;
    logic  merge_up;
    logic  free_init;
    logic  fr_en;
    fsel_e fr_sel;
    logic  fw_en;
    fsel_e fw_sel;
    logic  fw_val;
    logic  leaf_rd;
    logic  leaf_alloc;
    logic  load_out;
    res_e  res;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic bad_size;
    logic bad_free;
    logic fr_bit;
    logic pos_last;
    logic lvl_top;
    logic lvl_above;
    logic code_bad;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ rtl/bba_datapath.sv @@
// Datapath of the buddy block allocator: free-node store, leaf level store, walk registers.
module bba_datapath #(
  parameter int unsigned LEVELS = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bba_pkg::ctl_cmd_t           cmd_i,
  output bba_pkg::dp_stat_t           stat_o,
  input  logic                        cfg_we_i,
  input  logic [bba_pkg::AddrW-1:0]   cfg_data_i,
  input  logic                        in_cmd_i,
  input  logic [bba_pkg::SizeW-1:0]   req_size_i,
  input  logic [bba_pkg::AddrW-1:0]   free_addr_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bba_pkg::StatusW-1:0] status_o,
  output logic [bba_pkg::AddrW-1:0]   addr_o,
  output logic [bba_pkg::LvlW-1:0]    level_o
);
  import bba_pkg::*;

  localparam int unsigned NodeW     = LEVELS;
  localparam int unsigned LeafW     = LEVELS - 1;
  localparam int unsigned NodeCount = (1 << LEVELS) - 1;
  localparam int unsigned LeafCount = 1 << LeafW;
  localparam int unsigned Top       = LEVELS - 1;
  localparam int unsigned MinLog2   = $clog2(MinBlockBytes);
  localparam int unsigned PoolLog2  = MinLog2 + LeafW;
  localparam int unsigned TotalW    = SizeW + 1;

  logic             free_mem [NodeCount];
  logic [CodeW-1:0] leaf_mem [LeafCount];

  logic [AddrW-1:0] base_q;
  logic [NodeW-1:0] clr_cnt_q;
  logic             cmd_q;
  logic [LvlW-1:0]  want_q, want_d;
  logic             bad_size_q, bad_size_d;
  logic             bad_free_q, bad_free_d;
  logic [LeafW-1:0] leaf_q;
  logic [LvlW-1:0]  lvl_q;
  logic [LeafW-1:0] pos_q;
  logic [LvlW-1:0]  freed_q;
  logic             fr_bit_q;
  logic [CodeW-1:0] leaf_rd_q;
  logic             out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [AddrW-1:0] addr_q;
  logic [LvlW-1:0]  level_q;

  logic [TotalW-1:0] total;
  logic [AddrW-1:0]  free_off;
  logic [LvlW-1:0]   depth;
  logic [NodeW-1:0]  lvl_base, node_a, node_b, node_n;
  logic [NodeW-1:0]  fr_addr, fw_addr;
  logic              fw_en, fw_val;
  logic [LeafW-1:0]  alloc_leaf;
  logic [AddrW-1:0]  alloc_off;
  logic [LvlW-1:0]   code_lvl;
  logic              lw_en;
  logic [LeafW-1:0]  lw_addr;
  logic [CodeW-1:0]  lw_val;

  // Request decode.
  always_comb begin
    total      = TotalW'(req_size_i) + TotalW'(HeaderBytes);
    bad_size_d = (req_size_i == '0) ||
                 ({{(33 - TotalW){1'b0}}, total} > (33'(1) << PoolLog2));
    want_d     = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if ((33'(MinBlockBytes) << l) >= 33'(total)) want_d = LvlW'(l);
    end
    free_off   = free_addr_i - AddrW'(HeaderBytes) - base_q;
    bad_free_d = ((free_off >> PoolLog2) != '0) || (free_off[MinLog2-1:0] != '0);
  end

  // Tree node addressing.
  always_comb begin
    depth      = LvlW'(Top) - lvl_q;
    lvl_base   = (NodeW'(1) << depth) - NodeW'(1);
    node_a     = lvl_base + NodeW'(pos_q);
    node_n     = node_a + NodeW'(1);
    node_b     = lvl_base + NodeW'(pos_q ^ LeafW'(1));
    alloc_leaf = pos_q << want_q;
    alloc_off  = AddrW'(alloc_leaf) << MinLog2;
    code_lvl   = LvlW'(leaf_rd_q - CodeW'(1));
  end

  always_comb begin
    unique case (cmd_i.fr_sel)
      FSEL_BUDDY: fr_addr = node_b;
      FSEL_NEXT:  fr_addr = node_n;
      default:    fr_addr = node_a;
    endcase
    fw_en = cmd_i.fw_en || cmd_i.clr;
    if (cmd_i.clr) begin
      fw_addr = clr_cnt_q;
      fw_val  = (clr_cnt_q == '0);
    end else begin
      fw_val = cmd_i.fw_val;
      unique case (cmd_i.fw_sel)
        FSEL_BUDDY: fw_addr = node_b;
        FSEL_NEXT:  fw_addr = node_n;
        default:    fw_addr = node_a;
      endcase
    end
    lw_en = cmd_i.clr || cmd_i.free_init || cmd_i.leaf_alloc;
    priority if (cmd_i.clr) begin
      lw_addr = clr_cnt_q[LeafW-1:0];
      lw_val  = '0;
    end else if (cmd_i.leaf_alloc) begin
      lw_addr = alloc_leaf;
      lw_val  = CodeW'(want_q) + CodeW'(1);
    end else begin
      lw_addr = leaf_q;
      lw_val  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fw_en) free_mem[fw_addr] <= fw_val;
    if (cmd_i.fr_en) fr_bit_q <= free_mem[fr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) leaf_mem[lw_addr] <= lw_val;
    if (cmd_i.leaf_rd) leaf_rd_q <= leaf_mem[leaf_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      clr_cnt_q   <= '0;
      lvl_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) base_q <= cfg_data_i;
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + NodeW'(1);
      priority if (cmd_i.scan_init) begin
        lvl_q <= want_q;
        pos_q <= '0;
      end else if (cmd_i.scan_next) begin
        if (stat_o.pos_last) begin
          lvl_q <= lvl_q + LvlW'(1);
          pos_q <= '0;
        end else begin
          pos_q <= pos_q + LeafW'(1);
        end
      end else if (cmd_i.split_down) begin
        lvl_q <= lvl_q - LvlW'(1);
        pos_q <= pos_q << 1;
      end else if (cmd_i.merge_up) begin
        lvl_q <= lvl_q + LvlW'(1);
        pos_q <= pos_q >> 1;
      end else if (cmd_i.free_init) begin
        lvl_q <= code_lvl;
        pos_q <= leaf_q >> code_lvl;
      end
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q      <= in_cmd_i;
      want_q     <= want_d;
      bad_size_q <= bad_size_d;
      bad_free_q <= bad_free_d;
      leaf_q     <= free_off[MinLog2 +: LeafW];
    end
    if (cmd_i.free_init) freed_q <= code_lvl;
    if (cmd_i.load_out) begin
      status_q <= cmd_i.res;
      unique case (cmd_i.res)
        RES_ALLOC: begin
          addr_q  <= base_q + alloc_off + AddrW'(HeaderBytes);
          level_q <= want_q;
        end
        RES_FREED: begin
          addr_q  <= '0;
          level_q <= freed_q;
        end
        default: begin
          addr_q  <= '0;
          level_q <= '0;
        end
      endcase
    end
  end

  always_comb begin
    stat_o.clr_last  = (clr_cnt_q == NodeW'(NodeCount - 1));
    stat_o.is_free   = cmd_q;
    stat_o.bad_size  = bad_size_q;
    stat_o.bad_free  = bad_free_q;
    stat_o.fr_bit    = fr_bit_q;
    stat_o.pos_last  = (pos_q == lvl_base[LeafW-1:0]);
    stat_o.lvl_top   = (lvl_q == LvlW'(Top));
    stat_o.lvl_above = (lvl_q > want_q);
    stat_o.code_bad  = (leaf_rd_q == '0) || (leaf_rd_q > CodeW'(LEVELS));
    stat_o.out_busy  = out_valid_q && out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign addr_o      = addr_q;
  assign level_o     = level_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled result");
  a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LvlW'(Top))
    else $error("walk level beyond top of tree");
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.load_out))
    else $error("result appeared without a load");
`endif

endmodule

@@ rtl/bba_ctrl.sv @@
// Sequencing state machine of the buddy block allocator.
module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bba_pkg::dp_stat_t stat_i,
  output bba_pkg::ctl_cmd_t cmd_o
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT_CLR, S_SPLIT_L,
    S_SPLIT_R, S_ALLOC_FIN, S_LEAF_RD, S_LEAF_CHK, S_BUDDY_RD, S_BUDDY_CHK,
    S_FREE_FIN, S_RESP
  } state_e;

  state_e state_q;
  res_e   res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      res_q   <= RES_FAIL;
    end else begin
      unique case (state_q)
        S_CLEAR:  if (stat_i.clr_last) state_q <= S_IDLE;
        S_IDLE:   if (in_valid_i) state_q <= S_DECODE;
        S_DECODE: begin
          if (stat_i.is_free) begin
            if (stat_i.bad_free) begin
              res_q   <= RES_IGNORE;
              state_q <= S_RESP;
            end else begin
              state_q <= S_LEAF_RD;
            end
          end else if (stat_i.bad_size) begin
            res_q   <= RES_FAIL;
            state_q <= S_RESP;
          end else begin
            state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (stat_i.fr_bit) begin
            state_q <= stat_i.lvl_above ? S_SPLIT_CLR : S_ALLOC_FIN;
          end else if (stat_i.pos_last && stat_i.lvl_top) begin
            res_q   <= RES_FAIL;
            state_q <= S_RESP;
          end else begin
            state_q <= S_SCAN_RD;
          end
        end
        S_SPLIT_CLR: state_q <= S_SPLIT_L;
        S_SPLIT_L:   state_q <= S_SPLIT_R;
        S_SPLIT_R:   state_q <= stat_i.lvl_above ? S_SPLIT_CLR : S_ALLOC_FIN;
        S_ALLOC_FIN: begin
          res_q   <= RES_ALLOC;
          state_q <= S_RESP;
        end
        S_LEAF_RD:  state_q <= S_LEAF_CHK;
        S_LEAF_CHK: begin
          if (stat_i.code_bad) begin
            res_q   <= RES_IGNORE;
            state_q <= S_RESP;
          end else begin
            state_q <= S_BUDDY_RD;
          end
        end
        S_BUDDY_RD:  state_q <= stat_i.lvl_top ? S_FREE_FIN : S_BUDDY_CHK;
        S_BUDDY_CHK: state_q <= stat_i.fr_bit ? S_BUDDY_RD : S_FREE_FIN;
        S_FREE_FIN: begin
          res_q   <= RES_FREED;
          state_q <= S_RESP;
        end
        S_RESP:  if (!stat_i.out_busy) state_q <= S_IDLE;
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.res = res_q;
    unique case (state_q)
      S_CLEAR:     cmd_o.clr = 1'b1;
      S_IDLE:      cmd_o.capture = in_valid_i;
      S_DECODE:    cmd_o.scan_init = !stat_i.is_free && !stat_i.bad_size;
      S_SCAN_RD: begin
        cmd_o.fr_en  = 1'b1;
        cmd_o.fr_sel = FSEL_NODE;
      end
      S_SCAN_CHK:  cmd_o.scan_next = !stat_i.fr_bit && !(stat_i.pos_last && stat_i.lvl_top);
      S_SPLIT_CLR: begin
        cmd_o.fw_en      = 1'b1;
        cmd_o.fw_sel     = FSEL_NODE;
        cmd_o.fw_val     = 1'b0;
        cmd_o.split_down = 1'b1;
      end
      S_SPLIT_L: begin
        cmd_o.fw_en  = 1'b1;
        cmd_o.fw_sel = FSEL_NODE;
        cmd_o.fw_val = 1'b1;
      end
      S_SPLIT_R: begin
        cmd_o.fw_en  = 1'b1;
        cmd_o.fw_sel = FSEL_NEXT;
        cmd_o.fw_val = 1'b1;
      end
      S_ALLOC_FIN: begin
        cmd_o.fw_en      = 1'b1;
        cmd_o.fw_sel     = FSEL_NODE;
        cmd_o.fw_val     = 1'b0;
        cmd_o.leaf_alloc = 1'b1;
      end
      S_LEAF_RD:   cmd_o.leaf_rd = 1'b1;
      S_LEAF_CHK:  cmd_o.free_init = !stat_i.code_bad;
      S_BUDDY_RD: begin
        cmd_o.fr_en  = !stat_i.lvl_top;
        cmd_o.fr_sel = FSEL_BUDDY;
      end
      S_BUDDY_CHK: begin
        cmd_o.fw_en    = stat_i.fr_bit;
        cmd_o.fw_sel   = FSEL_BUDDY;
        cmd_o.fw_val   = 1'b0;
        cmd_o.merge_up = stat_i.fr_bit;
      end
      S_FREE_FIN: begin
        cmd_o.fw_en  = 1'b1;
        cmd_o.fw_sel = FSEL_NODE;
        cmd_o.fw_val = 1'b1;
      end
      S_RESP:      cmd_o.load_out = !stat_i.out_busy;
      default:     cmd_o = '0;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a transaction is in flight");
  a_resp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && !stat_i.out_busy) |=> (state_q == S_IDLE))
    else $error("response not retired");
`endif

endmodule

@@ rtl/buddy_block_allocator.sv @@
// Top level of the buddy block allocator: controller, datapath and ports.
//
// Buddy allocator over 2^(LEVELS-1) blocks of 1 KiB starting at pool_base.
// One transaction in at a time: in_stall_o stays high from acceptance until
// the result has been loaded into the output register, and the next request
// may be taken while that result still waits on out_stall_i. After reset the
// block runs a clearing pass over the free-node store before it takes the
// first request; pool_base writes are taken at any time (cfg_ready_o is
// always high). The single-port free-node store is touched once per cycle.
// An allocation scans tree positions (lowest free block first at the wanted
// level, then at each larger level), then splits that block down to the
// wanted level; a free reads the leaf code and merges with its buddy while
// the buddy is free. A request rejected at decode, and a free of a block
// that is not allocated, never touch the free-node store. Allocation is
// slowest when the pool is nearly full.
module buddy_block_allocator #(
  parameter int unsigned LEVELS = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pool_base write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bba_pkg::AddrW-1:0]   cfg_data_i,
  // request transaction
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [bba_pkg::SizeW-1:0]   req_size_i,
  input  logic [bba_pkg::AddrW-1:0]   free_addr_i,
  // result transaction
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bba_pkg::StatusW-1:0] status_o,
  output logic [bba_pkg::AddrW-1:0]   addr_o,
  output logic [bba_pkg::LvlW-1:0]    level_o
);
  import bba_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  bba_datapath #(
    .LEVELS (LEVELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctl_cmd),
    .stat_o      (dp_stat),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_cmd_i    (cmd_i),
    .req_size_i  (req_size_i),
    .free_addr_i (free_addr_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .addr_o      (addr_o),
    .level_o     (level_o)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the buddy block allocator: directed and random transactions.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int unsigned TopLvl    = 10;
  localparam int unsigned NodeCnt   = 2047;
  localparam int unsigned LeafCnt   = 1024;
  localparam int unsigned PoolBytes = MinBlockBytes * LeafCnt;
  // Room for the slowest allocation scans on every transaction, with
  // margin, plus the stall phases.
  localparam longint unsigned CycleLimit = 40000000;
  localparam int unsigned HoldOffCycles = 3000;

  typedef struct packed {
    res_e        status;
    logic [31:0] addr;
    logic [3:0]  level;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [AddrW-1:0]    cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                cmd_i = 1'b0;
  logic [SizeW-1:0]    req_size_i = '0;
  logic [AddrW-1:0]    free_addr_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [AddrW-1:0]    addr_o;
  logic [LvlW-1:0]     level_o;

  buddy_block_allocator dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .cmd_i, .req_size_i, .free_addr_i,
    .out_valid_o, .out_stall_i, .status_o, .addr_o, .level_o
  );

  // Shadow allocator state.
  bit          free_bit [NodeCnt];
  logic [4:0]  leaf_code [LeafCnt];
  logic [31:0] base_q;

  outcome_t    pending_q[$];
  int unsigned live_off[$];
  int unsigned errors = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_go = 1'b0;
  logic        hold_on = 1'b0;
  longint unsigned cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Cap the run; a hung block ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("buddy_block_allocator verification failed");
      $finish;
    end
  end

  function automatic int unsigned node_idx(int unsigned lvl, int unsigned pos);
    return ((1 << (TopLvl - lvl)) - 1) + pos;
  endfunction

  // Compute the outcome of one request and advance the shadow state.
  function automatic outcome_t predict_outcome(bit cmd, logic [20:0] size, logic [31:0] ptr);
    outcome_t    o;
    int unsigned total, want, lvl, pos, leaf, freed, cnt;
    bit          found;
    logic [31:0] off;
    o = '{status: RES_FAIL, addr: '0, level: '0};
    if (!cmd) begin
      total = size + HeaderBytes;
      if (size == 0 || total > PoolBytes) return o;
      want = 0;
      while ((MinBlockBytes << want) < total) want++;
      found = 1'b0;
      for (lvl = want; lvl <= TopLvl; lvl++) begin
        cnt = 1 << (TopLvl - lvl);
        for (pos = 0; pos < cnt; pos++) begin
          if (free_bit[node_idx(lvl, pos)]) begin
            found = 1'b1;
            break;
          end
        end
        if (found) break;
      end
      if (!found) return o;
      // Split down, keeping left halves.
      while (lvl > want) begin
        free_bit[node_idx(lvl, pos)] = 1'b0;
        lvl--;
        pos = pos * 2;
        free_bit[node_idx(lvl, pos)] = 1'b1;
        free_bit[node_idx(lvl, pos + 1)] = 1'b1;
      end
      free_bit[node_idx(want, pos)] = 1'b0;
      off = pos * (MinBlockBytes << want);
      leaf_code[off / MinBlockBytes] = 5'(want + 1);
      o.status = RES_ALLOC;
      o.addr   = base_q + off + HeaderBytes;
      o.level  = 4'(want);
    end else begin
      o.status = RES_IGNORE;
      off = ptr - HeaderBytes - base_q;
      if (off >= PoolBytes || (off % MinBlockBytes) != 0) return o;
      leaf = off / MinBlockBytes;
      if (leaf_code[leaf] == 0 || leaf_code[leaf] > TopLvl + 1) return o;
      lvl = leaf_code[leaf] - 1;
      freed = lvl;
      leaf_code[leaf] = 0;
      pos = leaf >> lvl;
      // Merge with the true buddy while it is free.
      while (lvl < TopLvl) begin
        if (!free_bit[node_idx(lvl, pos ^ 1)]) break;
        free_bit[node_idx(lvl, pos ^ 1)] = 1'b0;
        lvl++;
        pos = pos >> 1;
      end
      free_bit[node_idx(lvl, pos)] = 1'b1;
      o.status = RES_FREED;
      o.level  = 4'(freed);
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // Check every result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", {30'd0, status_o}, '0);
      end else begin
        outcome_t e;
        e = pending_q.pop_front();
        if (status_o !== e.status) report_mismatch("status", {30'd0, status_o}, {30'd0, e.status});
        if (addr_o !== e.addr) report_mismatch("addr", addr_o, e.addr);
        if (level_o !== e.level) report_mismatch("level", {28'd0, level_o}, {28'd0, e.level});
      end
    end
  end

  // Receiver: random stall, or a long hold-off when requested.
  always @(posedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(99) < stall_pct);
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // Predict, queue the expectation, then offer the transaction until taken.
  task automatic issue_req(bit cmd, logic [20:0] size, logic [31:0] ptr);
    outcome_t o;
    int       idx;
    o = predict_outcome(cmd, size, ptr);
    pending_q.push_back(o);
    if (o.status == RES_ALLOC) live_off.push_back(o.addr - base_q - HeaderBytes);
    if (o.status == RES_FREED) begin
      for (idx = 0; idx < live_off.size(); idx++) begin
        if (live_off[idx] == ptr - base_q - HeaderBytes) begin
          live_off.delete(idx);
          break;
        end
      end
    end
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    req_size_i  <= size;
    free_addr_i <= ptr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic alloc_bytes(logic [20:0] size);
    issue_req(1'b0, size, $urandom);
  endtask

  task automatic free_off(logic [31:0] off);
    issue_req(1'b1, 21'($urandom), base_q + off + HeaderBytes);
  endtask

  // Drain all results, then write pool_base while idle.
  task automatic set_pool_base(logic [31:0] value);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    base_q = value;
  endtask

  task automatic test_size_bounds();
    alloc_bytes(21'd0);
    alloc_bytes(21'd1);
    alloc_bytes(21'd1020);
    alloc_bytes(21'd1021);
    free_off(0);
    free_off(1024);
    free_off(2048);
    alloc_bytes(21'(PoolBytes - HeaderBytes));
    alloc_bytes(21'd1);
    free_off(0);
    alloc_bytes(21'(PoolBytes - HeaderBytes + 1));
    alloc_bytes(21'h1FFFFF);
  endtask

  task automatic test_bad_frees();
    alloc_bytes(21'd100);
    issue_req(1'b1, '0, base_q + HeaderBytes + 1);
    issue_req(1'b1, '0, base_q + HeaderBytes + PoolBytes);
    issue_req(1'b1, '1, 32'hFFFF_FFFF);
    issue_req(1'b1, '0, 32'h0000_0000);
    issue_req(1'b1, '0, base_q + HeaderBytes + 1024);
    free_off(0);
    free_off(0);
  endtask

  task automatic test_merge_chain();
    repeat (4) alloc_bytes(21'd1);
    free_off(1024);
    free_off(3072);
    free_off(0);
    free_off(2048);
  endtask

  // Mostly well-formed alloc/free traffic over live blocks, some noise.
  task automatic test_random_traffic(int unsigned count);
    int unsigned r, lvl, lo, hi, pick;
    repeat (count) begin
      r = $urandom_range(99);
      if (live_off.size() == 0 || r < 50) begin
        if ($urandom_range(99) < 6) begin
          alloc_bytes(21'($urandom_range(21'h1FFFFF)));
        end else begin
          lvl = $urandom_range(TopLvl);
          hi  = (MinBlockBytes << lvl) - HeaderBytes;
          lo  = (lvl == 0) ? 1 : (MinBlockBytes << (lvl - 1)) - HeaderBytes + 1;
          alloc_bytes(21'($urandom_range(hi, lo)));
        end
      end else if (r < 90) begin
        pick = $urandom_range(live_off.size() - 1);
        free_off(live_off[pick]);
      end else if (r < 95) begin
        issue_req(1'b1, 21'($urandom), $urandom);
      end else begin
        // Misaligned or stale pointer near the pool.
        free_off(($urandom_range(LeafCnt - 1) * MinBlockBytes) + $urandom_range(3));
      end
    end
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_go   = 1'b1;
    test_random_traffic(40);
  endtask

  task automatic release_all();
    while (live_off.size() != 0) free_off(live_off[0]);
  endtask

  initial begin
    for (int i = 0; i < NodeCnt; i++) free_bit[i] = 1'b0;
    for (int i = 0; i < LeafCnt; i++) leaf_code[i] = '0;
    free_bit[0] = 1'b1;
    base_q = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_size_bounds();
    test_bad_frees();
    test_merge_chain();

    set_pool_base(32'hFFFF_FFFF);
    idle_pct = 0;  stall_pct = 0;
    test_random_traffic(300);
    release_all();

    set_pool_base(32'hFFFF_F800);
    idle_pct = 64; stall_pct = 0;
    test_random_traffic(300);

    set_pool_base($urandom);
    idle_pct = 0;  stall_pct = 64;
    test_random_traffic(300);
    release_all();

    set_pool_base($urandom);
    idle_pct = 35; stall_pct = 35;
    test_random_traffic(300);

    set_pool_base(32'h0000_0000);
    test_backpressure();
    idle_pct = 35; stall_pct = 35;
    test_random_traffic(260);

    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("buddy_block_allocator verification clean");
    end else begin
      $display("buddy_block_allocator verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bba_pkg.sv
rtl/bba_datapath.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator.sv
tb/tb_top.sv
